[hdl/scba_pkg.sv]
// Shared types, constants and helpers for the size-class bump allocator.
`default_nettype none

package scba_pkg;

   // Sizing of the heap and of the class table
   localparam int unsigned NUM_BLOCKS       = 131072;
   localparam int unsigned BLOCK_BYTES      = 4096;
   localparam int unsigned HEADER_BYTES     = 8;
   localparam int unsigned MAX_OBJECT_BYTES = 2040;
   localparam int unsigned NUM_CLASSES      = MAX_OBJECT_BYTES + 1;

   // Derived widths
   localparam int unsigned ADDR_W      = 48;
   localparam int unsigned SIZE_W      = 16;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned BLOCK_IDX_W = $clog2(NUM_BLOCKS);
   localparam int unsigned FREE_CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int unsigned OFFSET_W    = $clog2(BLOCK_BYTES + 1);
   localparam int unsigned CLASS_W     = $clog2(NUM_CLASSES);
   localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int unsigned SUM_W       = SIZE_W + 2;
   localparam int unsigned RSP_DATA_W  = ((ADDR_W + 7) / 8) * 8;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_BLOCK  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   // One class table entry
   typedef struct packed {
      logic                   valid;
      logic [BLOCK_IDX_W-1:0] tail_block;
      logic [OFFSET_W-1:0]    fill_offset;
   } class_entry_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

   // Round a size up to the next multiple of 8
   function automatic logic [SUM_W-1:0] round_up8(input logic [SIZE_W-1:0] size);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(size) + SUM_W'(7);
      return {sum[SUM_W-1:3], 3'b000};
   endfunction

endpackage : scba_pkg

`default_nettype wire

[hdl/scba_ctrl.sv]
// Controller state machine: clearing pass, request intake and result hand-off.
`default_nettype none

module scba_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  scba_pkg::dp_status_type dp_status,
   output scba_pkg::ctrl_cmd_type  cmd
);
   import scba_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.lookup = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold the looked-up entry until the output register can take the request's result
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // An accepted request always moves on to execution
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not reach execution");

   // A result appears only after an execution step
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC))
      else $error("result raised without execution");

   // Commit never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

endmodule : scba_ctrl

`default_nettype wire

[hdl/scba_datapath.sv]
// Datapath: class table memory, free block counter, heap base and result registers.
`default_nettype none

module scba_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  scba_pkg::ctrl_cmd_type           cmd,
   output scba_pkg::dp_status_type          dp_status,
   input  wire [scba_pkg::SIZE_W-1:0]       req_size,
   input  wire                              csr_wr_en,
   input  wire [scba_pkg::ADDR_W-1:0]       csr_wr_data,
   output logic [scba_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [scba_pkg::STATUS_W-1:0]    rsp_tuser
);
   import scba_pkg::*;

   class_entry_type        class_mem [NUM_CLASSES];
   class_entry_type        rd_entry_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [CLASS_W-1:0]     clr_idx_ff, clr_idx_in;
   logic [FREE_CNT_W-1:0]  next_free_ff, next_free_in;
   logic [ADDR_W-1:0]      heap_base_ff, heap_base_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   status_type             status_ff, status_in;

   logic [CLASS_W-1:0]     rd_idx;
   logic [CLASS_W-1:0]     cur_idx;
   logic                   req_oversize;
   logic                   cur_oversize;
   logic [SUM_W-1:0]       rounded;
   logic                   too_large;
   logic                   fits;
   logic                   out_of_blocks;
   logic [BLOCK_IDX_W-1:0] use_block;
   logic [OFFSET_W-1:0]    use_offset;
   logic                   alloc_ok;
   logic                   mem_wr;
   logic [CLASS_W-1:0]     mem_wr_idx;
   class_entry_type        mem_wr_data;

   // Park the read address at zero for sizes beyond the table
   assign req_oversize = req_size > SIZE_W'(MAX_OBJECT_BYTES);
   assign rd_idx       = req_oversize ? '0 : req_size[CLASS_W-1:0];

   // Decode the held request
   assign cur_oversize = size_ff > SIZE_W'(MAX_OBJECT_BYTES);
   assign cur_idx      = cur_oversize ? '0 : size_ff[CLASS_W-1:0];
   assign rounded      = round_up8(size_ff);
   assign too_large    = cur_oversize ||
                         ((rounded + SUM_W'(HEADER_BYTES)) > SUM_W'(BLOCK_BYTES));
   assign fits         = rd_entry_ff.valid &&
                         ((SUM_W'(rd_entry_ff.fill_offset) + rounded) <= SUM_W'(BLOCK_BYTES));
   assign out_of_blocks = !fits && (next_free_ff >= FREE_CNT_W'(NUM_BLOCKS));

   // Pick the tail block or a fresh one
   always_comb begin
      if (fits) begin
         use_block  = rd_entry_ff.tail_block;
         use_offset = rd_entry_ff.fill_offset;
      end else begin
         use_block  = next_free_ff[BLOCK_IDX_W-1:0];
         use_offset = OFFSET_W'(HEADER_BYTES);
      end
   end

   assign alloc_ok = !too_large && !out_of_blocks;

   // Result and status
   always_comb begin
      priority if (too_large) begin
         status_in = STATUS_TOO_LARGE;
         addr_in   = '0;
      end else if (out_of_blocks) begin
         status_in = STATUS_NO_BLOCK;
         addr_in   = '0;
      end else begin
         status_in = STATUS_OK;
         addr_in   = heap_base_ff + (ADDR_W'(use_block) << BLOCK_SHIFT) + ADDR_W'(use_offset);
      end
   end

   // Table write: clearing pass or entry update
   always_comb begin
      mem_wr      = 1'b0;
      mem_wr_idx  = cur_idx;
      mem_wr_data = '0;
      if (cmd.clear_wr) begin
         mem_wr     = 1'b1;
         mem_wr_idx = clr_idx_ff;
      end else if (cmd.commit && alloc_ok) begin
         mem_wr                  = 1'b1;
         mem_wr_data.valid       = 1'b1;
         mem_wr_data.tail_block  = use_block;
         mem_wr_data.fill_offset = OFFSET_W'(SUM_W'(use_offset) + rounded);
      end
   end

   // Class table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         class_mem[mem_wr_idx] <= mem_wr_data;
      end
      if (cmd.lookup) begin
         rd_entry_ff <= class_mem[rd_idx];
      end
   end

   // Hold the request size
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         size_ff <= req_size;
      end
   end

   // Control counters and heap base
   assign clr_idx_in   = cmd.clear_wr ? clr_idx_ff + CLASS_W'(1) : clr_idx_ff;
   assign next_free_in = (cmd.commit && alloc_ok && !fits) ? next_free_ff + FREE_CNT_W'(1)
                                                           : next_free_ff;
   assign heap_base_in = csr_wr_en ? csr_wr_data : heap_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         next_free_ff <= '0;
         heap_base_ff <= '0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         next_free_ff <= next_free_in;
         heap_base_ff <= heap_base_in;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         addr_ff   <= addr_in;
         status_ff <= status_in;
      end
   end

   assign dp_status.clear_last = clr_idx_ff == CLASS_W'(NUM_CLASSES - 1);
   assign rsp_tdata = RSP_DATA_W'(addr_ff);
   assign rsp_tuser = status_ff;

   // The free counter never runs past the block count
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_CNT_W'(NUM_BLOCKS))
      else $error("free block counter overran");

   // The free counter moves only on a committed request
   a_free_on_commit: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff != $past(next_free_ff)) |-> $past(cmd.commit))
      else $error("free block counter moved without a commit");

endmodule : scba_datapath

`default_nettype wire

[hdl/size_class_bump_allocator.sv]
// Timing: an accepted request has its class table entry and size registered, and its result
// is registered on commit from the execute state. Flow: a new request is accepted only after
// the read then update of the last one's class table entry; a waiting result stalls the next commit.
// Reset: synchronous, active high; afterwards a clearing pass sweeps every entry of
// the class table and no request is accepted until it ends (heap base writes are taken).
// Top level of the size-class bump allocator.
`default_nettype none

module size_class_bump_allocator (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [15:0]                         req_tdata,   // [15:0] obj_bytes
   // result channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [scba_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [47:0] address
   output logic [scba_pkg::STATUS_W-1:0]      rsp_tuser,   // [1:0] status
   // heap base register
   input  wire                                csr_wr_en,
   input  wire [scba_pkg::ADDR_W-1:0]         csr_wr_data  // [47:0] heap_base
);
   import scba_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   scba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   scba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .req_size    (req_tdata[SIZE_W-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // A failed request always carries a zero address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> (rsp_tdata == '0))
      else $error("error result with non-zero address");

endmodule : size_class_bump_allocator

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the size-class bump allocator: directed and random runs.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scba_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned PHASE_ITEMS   = 430;

   // one expected allocation outcome
   typedef struct {
      logic [ADDR_W-1:0] address;
      status_type        status;
   } alloc_result_type;

   // Track class tails and the free block counter, queue expected outcomes
   class heap_tracker;
      bit                     class_live [NUM_CLASSES];
      bit [BLOCK_IDX_W-1:0]   class_block[NUM_CLASSES];
      bit [OFFSET_W-1:0]      class_fill [NUM_CLASSES];
      bit [FREE_CNT_W-1:0]    free_next;
      logic [ADDR_W-1:0]      heap_base;
      alloc_result_type       pending_allocs[$];
      int unsigned            fail_count;

      function new();
         free_next  = '0;
         heap_base  = '0;
         fail_count = 0;
         foreach (class_live[i]) class_live[i] = 1'b0;
      endfunction

      // Work out the outcome of one accepted request and advance the heap state
      function void note_request(input logic [SIZE_W-1:0] size);
         alloc_result_type r;
         int unsigned   rounded;
         int unsigned   blk;
         int unsigned   off;
         bit            granted;
         r.address = '0;
         r.status  = STATUS_OK;
         granted   = 1'b0;
         rounded   = ((int'(size) + 7) / 8) * 8;
         if (size > MAX_OBJECT_BYTES || HEADER_BYTES + rounded > BLOCK_BYTES) begin
            r.status = STATUS_TOO_LARGE;
         end else if (class_live[size] && int'(class_fill[size]) + rounded <= BLOCK_BYTES) begin
            blk     = class_block[size];
            off     = class_fill[size];
            granted = 1'b1;
         end else if (free_next >= NUM_BLOCKS) begin
            r.status = STATUS_NO_BLOCK;
         end else begin
            blk       = free_next;
            free_next = free_next + 1'b1;
            off       = HEADER_BYTES;
            granted   = 1'b1;
         end
         if (granted) begin
            class_live[size]  = 1'b1;
            class_block[size] = BLOCK_IDX_W'(blk);
            class_fill[size]  = OFFSET_W'(off + rounded);
            r.address = heap_base + ADDR_W'(blk) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(off);
         end
         pending_allocs.push_back(r);
      endfunction

      task report_mismatch(input string msg);
         fail_count++;
         $display("%0t ns mismatch: %s", $time, msg);
      endtask

      // Compare one accepted result with the oldest expected outcome
      task check_result(input logic [ADDR_W-1:0] address, input status_type status);
         alloc_result_type want;
         if (pending_allocs.size() == 0) begin
            report_mismatch($sformatf("result addr=%h status=%0d with no request pending",
                                      address, status));
         end else begin
            want = pending_allocs.pop_front();
            if (address !== want.address)
               report_mismatch($sformatf("address %h, expected %h", address, want.address));
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
         end
      endtask

      function int unsigned pending_count();
         return pending_allocs.size();
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata   = '0;    // [15:0] obj_bytes
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;           // [47:0] address
   logic [STATUS_W-1:0]    rsp_tuser;           // [1:0] status
   logic                   csr_wr_en   = 1'b0;
   logic [ADDR_W-1:0]      csr_wr_data = '0;    // [47:0] heap_base

   heap_tracker            tracker;
   int unsigned            req_idle_pct = 0;
   int unsigned            rsp_idle_pct = 0;
   int unsigned            stall_requests = 0;
   int unsigned            stall_served = 0;
   int unsigned            hold_left = 0;
   int unsigned            cycle_count = 0;
   logic [15:0]            hot_sizes[6];

   size_class_bump_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Record accepted requests and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata[ADDR_W-1:0], status_type'(rsp_tuser));
      end
   end

   // Drive the result ready: random back-pressure, plus a long hold on demand
   always @(negedge clock) begin
      if (stall_requests != stall_served) begin
         stall_served = stall_requests;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one request, with random idle cycles first, and hold until accepted
   task automatic send_request(input logic [15:0] size);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= size;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_count() != 0) @(negedge clock);
   endtask

   task automatic write_heap_base(input logic [ADDR_W-1:0] base);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      tracker.heap_base = base;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= ADDR_W'({$urandom, $urandom});
   endtask

   function automatic logic [ADDR_W-1:0] random_base();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   // Favour a few busy classes so tails cross block ends, mixed with noise
   function automatic logic [15:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40)      return hot_sizes[$urandom_range(5)];
      else if (roll < 65) return 16'($urandom_range(MAX_OBJECT_BYTES));
      else if (roll < 72) return 16'd0;
      else if (roll < 82) return 16'($urandom);
      else if (roll < 90) return 16'($urandom_range(MAX_OBJECT_BYTES + 8, MAX_OBJECT_BYTES - 8));
      else                return 16'($urandom_range(16, 1));
   endfunction

   task automatic random_phase(input int unsigned sender_idle, input int unsigned receiver_idle,
                               input bit long_hold);
      req_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      foreach (hot_sizes[i]) hot_sizes[i] = 16'($urandom_range(MAX_OBJECT_BYTES));
      hot_sizes[0] = 16'($urandom_range(584, 577));   // fills a block exactly
      if (long_hold) stall_requests++;
      repeat (PHASE_ITEMS) send_request(pick_size());
   endtask

   initial begin
      logic [15:0] directed_sizes[22];

      directed_sizes = '{
         16'd0, 16'd0, 16'd1, 16'd7, 16'd8, 16'd9,
         16'd2040, 16'd2040, 16'd2040, 16'd2041, 16'd65535, 16'd32768,
         16'd584, 16'd584, 16'd584, 16'd584, 16'd584, 16'd584, 16'd584, 16'd584,
         16'd2039, 16'd1};
      tracker = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, oversize, zero size, exact block fill; base wraps
      req_idle_pct = 19;
      rsp_idle_pct = 81;
      write_heap_base({{(ADDR_W-12){1'b1}}, 12'h000});
      foreach (directed_sizes[i]) send_request(directed_sizes[i]);

      // Random: three idling regimes, a fresh heap base each
      write_heap_base(random_base() & ~ADDR_W'(BLOCK_BYTES - 1));
      random_phase(19, 81, 1'b0);
      write_heap_base({ADDR_W{1'b1}});
      random_phase(81, 19, 1'b0);
      write_heap_base('0);
      random_phase(0, 0, 1'b1);

      drain();
      repeat (10) @(posedge clock);
      if (tracker.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
